[hw/rtl/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, constants and checksum helper for the TCP source port
// rewriter: frame offsets, register indexes, queue entry and hold write port.
// ----------------------------------------------------------------------------
package tsr_pkg;

	// Frame offsets (IPv4 header assumed 20 bytes, no VLAN tag)
	localparam int POS_W        = 6;
	localparam int POS_ETH_HI   = 12;
	localparam int POS_ETH_LO   = 13;
	localparam int POS_PROTO    = 23;
	localparam int POS_SRC_HI   = 34;
	localparam int POS_SRC_LO   = 35;
	localparam int POS_DST_HI   = 36;
	localparam int POS_DST_LO   = 37;
	localparam int POS_CSUM_HI  = 50;
	localparam int POS_CSUM_LO  = 51;
	localparam int HOLD_FIRST   = 34;
	localparam int HOLD_COUNT   = 20;
	localparam int POS_PAST     = 54;
	localparam int POS_DECIDE   = POS_PAST - 1;
	localparam int HOLD_IDX_W   = $clog2(HOLD_COUNT);

	// Places of rewritten bytes inside the held window
	localparam int HOLD_SRC_HI  = POS_SRC_HI - HOLD_FIRST;
	localparam int HOLD_SRC_LO  = POS_SRC_LO - HOLD_FIRST;
	localparam int HOLD_CSUM_HI = POS_CSUM_HI - HOLD_FIRST;
	localparam int HOLD_CSUM_LO = POS_CSUM_LO - HOLD_FIRST;

	// Header match values
	localparam logic [7:0] ETH_TYPE_HI = 8'h08;
	localparam logic [7:0] ETH_TYPE_LO = 8'h00;
	localparam logic [7:0] PROTO_TCP   = 8'd6;

	// Register reset values
	localparam logic [15:0] RANGE_LOW_RST   = 16'd25001;
	localparam logic [15:0] RANGE_HIGH_RST  = 16'd25004;
	localparam logic [15:0] REPL_PORT_RST   = 16'd25000;
	localparam logic [15:0] EXEMPT_PORT_RST = 16'd22;

	// Front-to-back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		REG_RANGE_LOW  = 2'd0,
		REG_RANGE_HIGH = 2'd1,
		REG_REPL_PORT  = 2'd2,
		REG_EXEMPT     = 2'd3
	} reg_idx_t;

	// One queue entry: a single pass-through byte, or a release of the window
	typedef struct packed {
		logic                  flush;
		logic [7:0]            data;
		logic                  last;
		logic [HOLD_IDX_W-1:0] last_idx;
		logic                  rewrite;
		logic [15:0]           repl_port;
		logic [15:0]           new_csum;
	} q_entry_t;

	// Hold window write from the front end
	typedef struct packed {
		logic                  en;
		logic [HOLD_IDX_W-1:0] idx;
		logic [7:0]            data;
	} hold_wr_t;

	// Ones-complement incremental update: ~(~hc + ~old + new)
	function automatic logic [15:0] csum_adjust(input logic [15:0] hc,
		input logic [15:0] old_v, input logic [15:0] new_v);
		logic [17:0] s;
		logic [16:0] f1;
		logic [15:0] f2;
		s  = {2'b00, ~hc} + {2'b00, ~old_v} + {2'b00, new_v};
		f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
		f2 = f1[15:0] + {15'd0, f1[16]};
		return ~f2;
	endfunction

endpackage

[hw/rtl/tcp_source_port_rewriter.sv]
// ----------------------------------------------------------------------------
// tcp_source_port_rewriter
// Byte-stream TCP source port rewrite with incremental checksum update.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  config  | cfg_we, cfg_index, cfg_data             | in
//  input   | in_valid, in_stall, data_byte, frame_end | in
//  output  | out_valid, out_stall, out_byte, out_last | out
//
//  Bytes outside the header window (offsets 0-33 and 54 on) pass through
//  the queue as single entries. A header window of up to 20 bytes leaves
//  the back end at one byte a cycle while out_stall is low; the front end
//  keeps accepting until the four-entry queue fills or a new window would
//  start before the previous one has drained. Reset is asynchronous and
//  restores the register defaults and an empty queue. Output stall freezes
//  the output register and, through the queue, the input.
// ----------------------------------------------------------------------------
module tcp_source_port_rewriter
	import tsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	q_entry_t q_wdata;
	q_entry_t q_head;
	hold_wr_t hold_wr;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	logic     drain_done;

	tsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata),
		.hold_wr    (hold_wr),
		.drain_done (drain_done)
	);

	tsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	tsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold_wr    (hold_wr),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.drain_done (drain_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

[hw/rtl/tsr_front.sv]
// ----------------------------------------------------------------------------
// tsr_front
// Accepts frame bytes, tracks the byte position, captures the header fields,
// writes the held window and pushes pass-through or release entries.
// ----------------------------------------------------------------------------
module tsr_front
	import tsr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      data_byte,
	input  logic            frame_end,
	input  logic            q_full,
	output logic            q_push,
	output q_entry_t        q_wdata,
	output hold_wr_t        hold_wr,
	input  logic            drain_done
);

	logic [15:0]      range_low_q;
	logic [15:0]      range_high_q;
	logic [15:0]      repl_port_q;
	logic [15:0]      exempt_q;
	logic [POS_W-1:0] pos_q;
	logic             is_ipv4_q;
	logic             is_tcp_q;
	logic [15:0]      src_port_q;
	logic [15:0]      dst_port_q;
	logic [15:0]      csum_q;
	logic             busy_q;

	logic             accept;
	logic             in_hold;
	logic             at_decide;
	logic             release_now;
	logic             qualify;
	logic [POS_W-1:0] pos_off;

	// Classify the current position
	always_comb begin
		in_hold     = (pos_q >= POS_W'(HOLD_FIRST)) && (pos_q < POS_W'(POS_PAST));
		at_decide   = (pos_q == POS_W'(POS_DECIDE));
		release_now = in_hold && (at_decide || frame_end);
		pos_off     = pos_q - POS_W'(HOLD_FIRST);
		in_stall    = q_full || (in_hold && busy_q);
		accept      = in_valid && !in_stall;
		qualify     = is_ipv4_q && is_tcp_q && at_decide &&
			(src_port_q != exempt_q) && (dst_port_q != exempt_q) &&
			(src_port_q >= range_low_q) && (src_port_q <= range_high_q);
	end

	// Build queue entry and hold write
	always_comb begin
		q_push            = accept && (!in_hold || release_now);
		q_wdata.flush     = in_hold;
		q_wdata.data      = data_byte;
		q_wdata.last      = frame_end;
		q_wdata.last_idx  = pos_off[HOLD_IDX_W-1:0];
		q_wdata.rewrite   = qualify;
		q_wdata.repl_port = repl_port_q;
		q_wdata.new_csum  = csum_adjust(csum_q, src_port_q, repl_port_q);
		hold_wr.en        = accept && in_hold;
		hold_wr.idx       = pos_off[HOLD_IDX_W-1:0];
		hold_wr.data      = data_byte;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			repl_port_q  <= REPL_PORT_RST;
			exempt_q     <= EXEMPT_PORT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				REG_REPL_PORT:  repl_port_q  <= cfg_data;
				REG_EXEMPT:     exempt_q     <= cfg_data;
				default:        range_low_q  <= range_low_q;
			endcase
		end
	end

	// Track the window until the back end has drained it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && release_now) begin
			busy_q <= 1'b1;
		end else if (drain_done) begin
			busy_q <= 1'b0;
		end
	end

	// Advance position and capture header fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			is_ipv4_q  <= 1'b0;
			is_tcp_q   <= 1'b0;
			src_port_q <= '0;
			dst_port_q <= '0;
			csum_q     <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q      <= '0;
				is_ipv4_q  <= 1'b0;
				is_tcp_q   <= 1'b0;
				src_port_q <= '0;
				dst_port_q <= '0;
				csum_q     <= '0;
			end else begin
				if (pos_q < POS_W'(POS_PAST)) begin
					pos_q <= pos_q + POS_W'(1);
				end
				unique case (pos_q)
					POS_W'(POS_ETH_HI):  is_ipv4_q <= (data_byte == ETH_TYPE_HI);
					POS_W'(POS_ETH_LO):  is_ipv4_q <= is_ipv4_q && (data_byte == ETH_TYPE_LO);
					POS_W'(POS_PROTO):   is_tcp_q  <= (data_byte == PROTO_TCP);
					POS_W'(POS_SRC_HI):  src_port_q[15:8] <= data_byte;
					POS_W'(POS_SRC_LO):  src_port_q[7:0]  <= data_byte;
					POS_W'(POS_DST_HI):  dst_port_q[15:8] <= data_byte;
					POS_W'(POS_DST_LO):  dst_port_q[7:0]  <= data_byte;
					POS_W'(POS_CSUM_HI): csum_q[15:8]     <= data_byte;
					POS_W'(POS_CSUM_LO): csum_q[7:0]      <= data_byte;
					default:             csum_q           <= csum_q;
				endcase
			end
		end
	end

endmodule

[hw/rtl/tsr_queue.sv]
// ----------------------------------------------------------------------------
// tsr_queue
// Short FIFO of front-end entries between the front and back ends.
// ----------------------------------------------------------------------------
module tsr_queue
	import tsr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wdata,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[hw/rtl/tsr_back.sv]
// ----------------------------------------------------------------------------
// tsr_back
// Holds the header window and carries out queue entries: emits pass-through
// bytes and drains released windows one byte a cycle unless out_stall holds
// them, with port and checksum substitution, through an output register.
// ----------------------------------------------------------------------------
module tsr_back
	import tsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  hold_wr_t   hold_wr,
	input  q_entry_t   head,
	input  logic       empty,
	output logic       pop,
	output logic       drain_done,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [7:0]            hold_q [HOLD_COUNT];
	logic [HOLD_IDX_W-1:0] idx_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	logic                  load;
	logic                  idx_end;
	logic [7:0]            win_byte;
	logic [7:0]            next_byte;
	logic                  next_last;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Select the next byte to emit
	always_comb begin
		load    = !empty && (!out_valid_q || !out_stall);
		idx_end = (idx_q == head.last_idx);
		win_byte = hold_q[idx_q];
		if (head.rewrite) begin
			unique case (idx_q)
				HOLD_IDX_W'(HOLD_SRC_HI):  win_byte = head.repl_port[15:8];
				HOLD_IDX_W'(HOLD_SRC_LO):  win_byte = head.repl_port[7:0];
				HOLD_IDX_W'(HOLD_CSUM_HI): win_byte = head.new_csum[15:8];
				HOLD_IDX_W'(HOLD_CSUM_LO): win_byte = head.new_csum[7:0];
				default:                   win_byte = hold_q[idx_q];
			endcase
		end
		if (head.flush) begin
			next_byte = win_byte;
			next_last = head.last && idx_end;
		end else begin
			next_byte = head.data;
			next_last = head.last;
		end
		pop        = load && (!head.flush || idx_end);
		drain_done = load && head.flush && idx_end;
	end

	// Write the held window
	always_ff @(posedge clk) begin
		if (hold_wr.en) begin
			hold_q[hold_wr.idx] <= hold_wr.data;
		end
	end

	// Step through a released window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load && head.flush) begin
			if (idx_end) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + HOLD_IDX_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

endmodule
